@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the loop detector RTL.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked at every clock edge outside reset.
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/fld_pkg.sv @@
// Shared types and constants of the forwarding loop detector.
// No dependencies; imported by every module of the block.
package fld_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);

  // Queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  localparam logic [31:0] LIFETIME_RESET = 32'd30000000;

  // One forwarded packet
  typedef struct packed {
    logic [31:0] pkt_id;
    logic [7:0]  hops_left;
    logic [63:0] now_us;
  } item_t;

endpackage

@@ rtl/core/forwarding_loop_detector_core.sv @@
// Forwarding loop detector, top level.
// Input channel: in_valid/in_stall with packet id, hop limit and current time.
// Output channel: out_valid/out_stall with one loop_detected flag per item.
// Config channel: cfg_valid/cfg_ready writes the entry lifetime in us;
// cfg_ready is always high, write only while the block is idle.
// Items wait in a two-entry queue; the back part takes one item at a time.
// From input accept, an item passes the queue, then the ST_LOOK and ST_DECIDE
// states, then the output register. Each item takes ST_LOOK and ST_DECIDE when
// the id hits or a slot is free; when the table is full and the id misses, the
// back part also searches for the oldest entry in ST_SCAN, one slot per cycle.
// Reset (synchronous, rst_n low) empties the table and the queue and loads
// the lifetime with 30000000.
// A stalled result holds in the output register; the back part waits with
// the next result, and in_stall rises once the queue is full.
// Depends on fld_pkg, fld_front and fld_back.
module forwarding_loop_detector_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_entry_lifetime_us,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_pkt_id,
  input  logic [7:0]  in_hops_left,
  input  logic [63:0] in_now_us,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_loop_detected
);
  import fld_pkg::*;

  logic [31:0] lifetime_r;
  logic        q_valid;
  logic        q_pop;
  item_t       q_item;

  assign cfg_ready = 1'b1;

  // Lifetime register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lifetime_r <= LIFETIME_RESET;
    end else if (cfg_valid && cfg_ready) begin
      lifetime_r <= cfg_entry_lifetime_us;
    end
  end

  fld_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_pkt_id    (in_pkt_id),
    .in_hops_left (in_hops_left),
    .in_now_us    (in_now_us),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop)
  );

  fld_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .lifetime          (lifetime_r),
    .q_valid           (q_valid),
    .q_item            (q_item),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_loop_detected (out_loop_detected)
  );

endmodule

@@ rtl/core/fld_front.sv @@
// Front of the loop detector: accepts items and buffers them in a short queue.
// Depends on fld_pkg.
`include "assert_macros.svh"

module fld_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [31:0]     in_pkt_id,
  input  logic [7:0]      in_hops_left,
  input  logic [63:0]     in_now_us,
  output logic            q_valid,
  output fld_pkg::item_t  q_item,
  input  logic            q_pop
);
  import fld_pkg::*;

  item_t               q_mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   q_cnt_r, q_cnt_nxt;
  logic                push;
  item_t               in_item;

  assign in_stall = (q_cnt_r == QCNT_W'(QDEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (q_cnt_r != '0);
  assign q_item   = q_mem_r[rd_ptr_r];

  always_comb begin
    in_item.pkt_id    = in_pkt_id;
    in_item.hops_left = in_hops_left;
    in_item.now_us    = in_now_us;
  end

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = push  ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    q_cnt_nxt  = q_cnt_r;
    if (push && !q_pop) begin
      q_cnt_nxt = q_cnt_r + 1'b1;
    end else if (q_pop && !push) begin
      q_cnt_nxt = q_cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      q_cnt_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      q_cnt_r  <= q_cnt_nxt;
    end
  end

  // Queue storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= in_item;
    end
  end

  `ASSERT_ALWAYS(a_q_cnt_bound, q_cnt_r <= QCNT_W'(QDEPTH), "queue count over depth")
  `ASSERT_IMPLY(a_pop_nonempty, q_pop, q_cnt_r != '0, "pop from empty queue")

endmodule

@@ rtl/core/fld_back.sv @@
// Back of the loop detector: packet table, expiry, match and replacement.
// Depends on fld_pkg; fed by fld_front through its queue.
`include "assert_macros.svh"

module fld_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [31:0]     lifetime,
  input  logic            q_valid,
  input  fld_pkg::item_t  q_item,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic            out_loop_detected
);
  import fld_pkg::*;

  typedef enum logic [1:0] {
    ST_LOOK,
    ST_DECIDE,
    ST_SCAN
  } state_t;

  state_t state_r;

  // Packet table
  logic [TABLE_DEPTH-1:0] valid_r;
  logic [31:0]            id_r    [TABLE_DEPTH];
  logic [7:0]             hl_r    [TABLE_DEPTH];
  logic [63:0]            first_r [TABLE_DEPTH];

  // Item under work
  item_t                  cur_r;
  logic                   hit_r;
  logic                   mism_r;

  // Oldest-entry scan
  logic [IDX_W-1:0]       scan_idx_r;
  logic [IDX_W-1:0]       best_idx_r;
  logic [63:0]            best_val_r;

  logic                   out_valid_r;
  logic                   out_loop_r;

  logic [TABLE_DEPTH-1:0] live;
  logic [TABLE_DEPTH-1:0] hit_vec;
  logic [TABLE_DEPTH-1:0] mism_vec;
  logic [IDX_W-1:0]       free_idx;
  logic                   out_free;
  logic                   scan_less;
  logic                   scan_last;
  logic                   wr_en;
  logic [IDX_W-1:0]       wr_idx;
  logic                   emit;

  assign out_valid         = out_valid_r;
  assign out_loop_detected = out_loop_r;
  assign out_free          = !out_valid_r || !out_stall;
  assign q_pop             = (state_r == ST_LOOK) && q_valid;

  // Expiry and id match on every slot in parallel
  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      live[i]     = valid_r[i] && ((q_item.now_us - first_r[i]) <= {32'd0, lifetime});
      hit_vec[i]  = live[i] && (id_r[i] == q_item.pkt_id);
      mism_vec[i] = hit_vec[i] && (hl_r[i] != q_item.hops_left);
    end
  end

  // Lowest free slot
  always_comb begin
    free_idx = '0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end

  assign scan_less = first_r[scan_idx_r] < best_val_r;
  assign scan_last = (scan_idx_r == IDX_W'(TABLE_DEPTH - 1));

  // Table write and result emission
  always_comb begin
    wr_en  = 1'b0;
    wr_idx = free_idx;
    emit   = 1'b0;
    unique case (state_r)
      ST_LOOK: begin
      end
      ST_DECIDE: begin
        if (out_free) begin
          if (hit_r) begin
            emit = 1'b1;
          end else if (!(&valid_r)) begin
            emit  = 1'b1;
            wr_en = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        if (out_free && scan_last) begin
          emit   = 1'b1;
          wr_en  = 1'b1;
          wr_idx = scan_less ? scan_idx_r : best_idx_r;
        end
      end
      default: begin
      end
    endcase
  end

  // Sequencer, valid bits and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOOK;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (wr_en) begin
        valid_r[wr_idx] <= 1'b1;
      end
      unique case (state_r)
        ST_LOOK: begin
          if (q_valid) begin
            valid_r <= live;
            state_r <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          if (out_free) begin
            if (hit_r || !(&valid_r)) begin
              state_r <= ST_LOOK;
            end else begin
              state_r <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (scan_last && out_free) begin
            state_r <= ST_LOOK;
          end
        end
        default: begin
          state_r <= ST_LOOK;
        end
      endcase
    end
  end

  // Datapath registers, no reset needed
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r  <= q_item;
      hit_r  <= |hit_vec;
      mism_r <= |mism_vec;
    end
    if (emit) begin
      out_loop_r <= hit_r && mism_r;
    end
    if (state_r == ST_DECIDE) begin
      scan_idx_r <= IDX_W'(1);
      best_idx_r <= '0;
      best_val_r <= first_r[0];
    end else if (state_r == ST_SCAN && !scan_last) begin
      if (scan_less) begin
        best_idx_r <= scan_idx_r;
        best_val_r <= first_r[scan_idx_r];
      end
      scan_idx_r <= scan_idx_r + 1'b1;
    end
    if (wr_en) begin
      id_r[wr_idx]    <= cur_r.pkt_id;
      hl_r[wr_idx]    <= cur_r.hops_left;
      first_r[wr_idx] <= cur_r.now_us;
    end
  end

  `ASSERT_IMPLY(a_scan_full, state_r == ST_SCAN, &valid_r, "replacement scan with free slot")
  `ASSERT_IMPLY(a_scan_idx, state_r == ST_SCAN, scan_idx_r != '0, "scan index at slot zero")
  `ASSERT_IMPLY(a_emit_free, emit, out_free, "result over an untaken result")

endmodule
